/* hdl/qema_pkg.sv */
// ----------------------------------------------------------------------------
// qema_pkg
// Types and constants shared by the element matrix assembly block.
// ----------------------------------------------------------------------------
package qema_pkg;

	localparam int IN_W     = 24;
	localparam int OUT_W    = 32;
	localparam int MAG_W    = 48;
	localparam int DIG_W    = 12;
	localparam int MUL_STEPS = MAG_W / DIG_W;
	localparam int PROD_W   = 2 * MAG_W;
	localparam int RND_POS  = 59;
	localparam int OUT_LSB  = 60;

	typedef enum logic [1:0] {
		OP_STIFF,
		OP_MASS,
		OP_PEVEN,
		OP_PODD
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_I,
		S_RD_J,
		S_SCALE,
		S_GXX,
		S_INNER,
		S_MSTART,
		S_MWAIT,
		S_ACC,
		S_ROUND
	} state_t;

endpackage

/* hdl/qema_ram.sv */
// ----------------------------------------------------------------------------
// qema_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module qema_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/qema_mul.sv */
// ----------------------------------------------------------------------------
// qema_mul
// Unsigned serial multiplier that takes one digit of the second operand per
// cycle, most significant digit first.
// ----------------------------------------------------------------------------
module qema_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qema_pkg::MAG_W-1:0]  a,
	input  logic [qema_pkg::MAG_W-1:0]  b,
	output logic                        done,
	output logic [qema_pkg::PROD_W-1:0] p
);

	localparam int CNT_W = (qema_pkg::MUL_STEPS > 1) ? $clog2(qema_pkg::MUL_STEPS) : 1;
	localparam int PART_W = qema_pkg::MAG_W + qema_pkg::DIG_W;

	logic [qema_pkg::MAG_W-1:0]  a_q;
	logic [qema_pkg::MAG_W-1:0]  b_q;
	logic [qema_pkg::PROD_W-1:0] p_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [PART_W-1:0]           part_raw;
	logic [qema_pkg::PROD_W-1:0] partial;

	assign part_raw = PART_W'(a_q) * PART_W'(b_q[qema_pkg::MAG_W-1 -: qema_pkg::DIG_W]);
	assign partial  = qema_pkg::PROD_W'(part_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(qema_pkg::MUL_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (run_q) begin
			p_q <= (p_q << qema_pkg::DIG_W) + partial;
			b_q <= b_q << qema_pkg::DIG_W;
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

/* hdl/qema_round.sv */
// ----------------------------------------------------------------------------
// qema_round
// Rounds an exact sum with 80 fraction bits to Q12.20, half toward plus
// infinity, and saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module qema_round #(
	parameter int ACC_W = 98
) (
	input  logic signed [ACC_W-1:0]          acc,
	output logic signed [qema_pkg::OUT_W-1:0] value
);

	localparam int TOP_LSB = qema_pkg::OUT_LSB + qema_pkg::OUT_W - 1;

	logic signed [ACC_W-1:0]     sum;
	logic [ACC_W-TOP_LSB-1:0]    top;

	assign sum = acc + (ACC_W'(1) << qema_pkg::RND_POS);
	assign top = sum[ACC_W-1:TOP_LSB];

	always_comb begin
		if (sum[ACC_W-1] && !(&top)) begin
			value = {1'b1, {(qema_pkg::OUT_W-1){1'b0}}};
		end else if (!sum[ACC_W-1] && (|top)) begin
			value = {1'b0, {(qema_pkg::OUT_W-1){1'b1}}};
		end else begin
			value = sum[TOP_LSB:qema_pkg::OUT_LSB];
		end
	end

endmodule

/* hdl/quad_element_matrix_assembly.sv */
// ----------------------------------------------------------------------------
// quad_element_matrix_assembly
// Local stiffness, mass and gradient-perp matrices of one Q1 element, built
// from quadrature rows held in two memories.
//
// Channel   Handshake              Payload
// input     start / busy           point_index .. end_of_element
// result    result_valid (strobe)  row_basis .. last_entry
//
// A row without the end flag leaves the block idle. After the end row, the
// NUM_BASIS*NUM_BASIS results come one at a time, paced by the one
// serial multiplier that forms every point term in four digit steps.
// Reset clears the control state only; the row memories hold no reset value.
// Each result is shown for one cycle; the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module quad_element_matrix_assembly #(
	parameter int NUM_BASIS  = 4,
	parameter int NUM_POINTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         point_index,
	input  logic [1:0]         basis_index,
	input  logic signed [23:0] quad_weight,
	input  logic signed [23:0] jacobian_det,
	input  logic signed [23:0] basis_value,
	input  logic signed [23:0] grad_x,
	input  logic signed [23:0] grad_y,
	input  logic               end_of_element,
	output logic               result_valid,
	output logic [1:0]         row_basis,
	output logic [1:0]         col_basis,
	output logic signed [31:0] stiffness_value,
	output logic signed [31:0] mass_value,
	output logic signed [31:0] perp_even_value,
	output logic signed [31:0] perp_odd_value,
	output logic               last_entry
);

	localparam int NUM_ENT = NUM_BASIS * NUM_POINTS;
	localparam int PW      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int BW      = (NUM_BASIS > 1) ? $clog2(NUM_BASIS) : 1;
	localparam int EW      = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
	localparam int ACC_W   = qema_pkg::PROD_W + 1 + $clog2(NUM_POINTS);
	localparam int IW      = qema_pkg::IN_W;

	qema_pkg::state_t state_q, state_d;
	qema_pkg::op_t    q_q;

	logic [BW-1:0] i_q, j_q;
	logic [PW-1:0] k_q;

	logic accept, wr_ok, last_k, last_pair, last_op;
	logic mul_start, mul_done;
	logic [qema_pkg::PROD_W-1:0] mul_p;
	logic [qema_pkg::MAG_W-1:0]  x_mag;
	logic term_neg;

	logic [PW-1:0]     pt_raddr;
	logic [EW-1:0]     bs_raddr, bs_waddr;
	logic [2*IW-1:0]   pt_rdata;
	logic [3*IW-1:0]   bs_rdata;

	logic signed [IW-1:0] w_q, d_q, vi_q, gxi_q, gyi_q, vj_q, gxj_q, gyj_q;
	logic [IW-1:0]        abs_w, abs_d;
	logic [qema_pkg::MAG_W-1:0] s_mag_q;
	logic                 s_neg_q;
	logic signed [IW-1:0] op_a, op_b;
	logic signed [2*IW-1:0] prod;
	logic signed [2*IW-1:0] gp_q;
	logic signed [2*IW:0]   x_q;
	logic signed [ACC_W-1:0] term_q;
	logic signed [ACC_W-1:0] acc_q [4];

	logic signed [qema_pkg::OUT_W-1:0] rnd_st, rnd_ms, rnd_pe, rnd_po;
	logic valid_q, last_q;
	logic [1:0] row_q, col_q;
	logic signed [qema_pkg::OUT_W-1:0] st_q, ms_q, pe_q, po_q;

	assign accept    = start && !busy;
	assign wr_ok     = (32'(point_index) < NUM_POINTS) && (32'(basis_index) < NUM_BASIS);
	assign bs_waddr  = EW'(32'(basis_index) * NUM_POINTS + 32'(point_index));
	assign last_k    = (k_q == PW'(NUM_POINTS - 1));
	assign last_pair = (i_q == BW'(NUM_BASIS - 1)) && (j_q == BW'(NUM_BASIS - 1));
	assign last_op   = (q_q == qema_pkg::OP_PODD);

	qema_ram #(.WIDTH(2 * IW), .DEPTH(NUM_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (accept && wr_ok),
		.waddr (PW'(point_index)),
		.wdata ({quad_weight, jacobian_det}),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	qema_ram #(.WIDTH(3 * IW), .DEPTH(NUM_ENT)) u_bs_ram (
		.clk   (clk),
		.we    (accept && wr_ok),
		.waddr (bs_waddr),
		.wdata ({basis_value, grad_x, grad_y}),
		.raddr (bs_raddr),
		.rdata (bs_rdata)
	);

	assign x_mag = x_q[2*IW] ? qema_pkg::MAG_W'(-x_q) : qema_pkg::MAG_W'(x_q);

	qema_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (s_mag_q),
		.b      (x_mag),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			qema_pkg::S_IDLE: begin
				if (accept && end_of_element) begin
					state_d = qema_pkg::S_RD_I;
				end
			end
			qema_pkg::S_RD_I:   state_d = qema_pkg::S_RD_J;
			qema_pkg::S_RD_J:   state_d = qema_pkg::S_SCALE;
			qema_pkg::S_SCALE:  state_d = qema_pkg::S_GXX;
			qema_pkg::S_GXX:    state_d = qema_pkg::S_INNER;
			qema_pkg::S_INNER:  state_d = qema_pkg::S_MSTART;
			qema_pkg::S_MSTART: state_d = qema_pkg::S_MWAIT;
			qema_pkg::S_MWAIT: begin
				if (mul_done) begin
					state_d = qema_pkg::S_ACC;
				end
			end
			qema_pkg::S_ACC: begin
				if (!last_op) begin
					state_d = qema_pkg::S_INNER;
				end else if (last_k) begin
					state_d = qema_pkg::S_ROUND;
				end else begin
					state_d = qema_pkg::S_RD_I;
				end
			end
			qema_pkg::S_ROUND: begin
				state_d = last_pair ? qema_pkg::S_IDLE : qema_pkg::S_RD_I;
			end
			default: state_d = qema_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != qema_pkg::S_IDLE);
		mul_start = (state_q == qema_pkg::S_MSTART);
		pt_raddr  = k_q;
		bs_raddr  = EW'(32'(i_q) * NUM_POINTS + 32'(k_q));
		case (state_q)
			qema_pkg::S_RD_J: bs_raddr = EW'(32'(j_q) * NUM_POINTS + 32'(k_q));
			default:          bs_raddr = EW'(32'(i_q) * NUM_POINTS + 32'(k_q));
		endcase
	end

	always_comb begin
		op_a = vi_q;
		op_b = gxj_q;
		case (state_q)
			qema_pkg::S_GXX: begin
				op_a = gxi_q;
				op_b = gxj_q;
			end
			default: begin
				case (q_q)
					qema_pkg::OP_STIFF: begin
						op_a = gyi_q;
						op_b = gyj_q;
					end
					qema_pkg::OP_MASS:  op_b = vj_q;
					qema_pkg::OP_PEVEN: op_b = gyj_q;
					default:            op_b = gxj_q;
				endcase
			end
		endcase
	end

	assign prod     = op_a * op_b;
	assign abs_w    = w_q[IW-1] ? IW'(-w_q) : IW'(w_q);
	assign abs_d    = d_q[IW-1] ? IW'(-d_q) : IW'(d_q);
	assign term_neg = s_neg_q ^ x_q[2*IW]
		^ ((q_q == qema_pkg::OP_STIFF) || (q_q == qema_pkg::OP_PEVEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qema_pkg::S_IDLE;
			q_q     <= qema_pkg::OP_STIFF;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= 1'b0;
			case (state_q)
				qema_pkg::S_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				qema_pkg::S_GXX: q_q <= qema_pkg::OP_STIFF;
				qema_pkg::S_ACC: begin
					q_q <= qema_pkg::op_t'(q_q + 2'd1);
					if (last_op && !last_k) begin
						k_q <= k_q + 1'b1;
					end
				end
				qema_pkg::S_ROUND: begin
					valid_q <= 1'b1;
					k_q     <= '0;
					if (j_q == BW'(NUM_BASIS - 1)) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			qema_pkg::S_IDLE: begin
				for (int n = 0; n < 4; n++) begin
					acc_q[n] <= '0;
				end
			end
			qema_pkg::S_RD_J: begin
				w_q   <= pt_rdata[2*IW-1:IW];
				d_q   <= pt_rdata[IW-1:0];
				vi_q  <= bs_rdata[3*IW-1:2*IW];
				gxi_q <= bs_rdata[2*IW-1:IW];
				gyi_q <= bs_rdata[IW-1:0];
			end
			qema_pkg::S_SCALE: begin
				vj_q    <= bs_rdata[3*IW-1:2*IW];
				gxj_q   <= bs_rdata[2*IW-1:IW];
				gyj_q   <= bs_rdata[IW-1:0];
				s_mag_q <= qema_pkg::MAG_W'(abs_w) * qema_pkg::MAG_W'(abs_d);
				s_neg_q <= w_q[IW-1];
			end
			qema_pkg::S_GXX: gp_q <= prod;
			qema_pkg::S_INNER: begin
				if (q_q == qema_pkg::OP_STIFF) begin
					x_q <= (2*IW+1)'(prod) + (2*IW+1)'(gp_q);
				end else begin
					x_q <= (2*IW+1)'(prod);
				end
			end
			qema_pkg::S_MWAIT: begin
				if (mul_done) begin
					term_q <= term_neg ? -ACC_W'(mul_p) : ACC_W'(mul_p);
				end
			end
			qema_pkg::S_ACC: acc_q[q_q] <= acc_q[q_q] + term_q;
			qema_pkg::S_ROUND: begin
				row_q  <= 2'(i_q);
				col_q  <= 2'(j_q);
				last_q <= last_pair;
				st_q   <= rnd_st;
				ms_q   <= rnd_ms;
				pe_q   <= rnd_pe;
				po_q   <= rnd_po;
				for (int n = 0; n < 4; n++) begin
					acc_q[n] <= '0;
				end
			end
			default: ;
		endcase
	end

	qema_round #(.ACC_W(ACC_W)) u_rnd_st (.acc(acc_q[qema_pkg::OP_STIFF]), .value(rnd_st));
	qema_round #(.ACC_W(ACC_W)) u_rnd_ms (.acc(acc_q[qema_pkg::OP_MASS]),  .value(rnd_ms));
	qema_round #(.ACC_W(ACC_W)) u_rnd_pe (.acc(acc_q[qema_pkg::OP_PEVEN]), .value(rnd_pe));
	qema_round #(.ACC_W(ACC_W)) u_rnd_po (.acc(acc_q[qema_pkg::OP_PODD]),  .value(rnd_po));

	assign result_valid    = valid_q;
	assign row_basis       = row_q;
	assign col_basis       = col_q;
	assign stiffness_value = st_q;
	assign mass_value      = ms_q;
	assign perp_even_value = pe_q;
	assign perp_odd_value  = po_q;
	assign last_entry      = last_q;

	a_valid_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == qema_pkg::S_ROUND))
		else $error("result strobe without a rounding step");

	a_last_ends_element: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_entry |-> state_q == qema_pkg::S_IDLE)
		else $error("final result of the element while still busy");

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == qema_pkg::S_MWAIT)
		else $error("multiplier finished outside its wait state");

	a_end_row_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && end_of_element |=> busy)
		else $error("end-of-element transaction did not start the computation");

endmodule

/* test/tb_quad_element_matrix_assembly.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quad_element_matrix_assembly
// Self-checking bench for the Q1 element matrix assembly block. Quadrature
// rows are sent in bursts. An internal copy of the row memories predicts the
// sixteen stiffness, mass and gradient-perp entries of every element. A short
// table of directed rows comes first, then random elements.
// ----------------------------------------------------------------------------
module tb_quad_element_matrix_assembly;

	localparam int NB        = 4;
	localparam int NP        = 4;
	localparam int CYCLE_CAP = 3000000;
	localparam int N_RANDOM  = 430;

	typedef enum int {
		CHK_PREDICT,
		CHK_ZERO,
		CHK_SAT
	} chk_t;

	typedef struct {
		logic [1:0]         pt;
		logic [1:0]         bs;
		logic signed [23:0] w;
		logic signed [23:0] d;
		logic signed [23:0] v;
		logic signed [23:0] gx;
		logic signed [23:0] gy;
		logic               eoe;
		chk_t               chk;
	} row_t;

	typedef struct {
		logic [1:0]         i;
		logic [1:0]         j;
		logic signed [31:0] stiff;
		logic signed [31:0] mass;
		logic signed [31:0] peven;
		logic signed [31:0] podd;
		logic               last;
	} entry_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         point_index;
	logic [1:0]         basis_index;
	logic signed [23:0] quad_weight;
	logic signed [23:0] jacobian_det;
	logic signed [23:0] basis_value;
	logic signed [23:0] grad_x;
	logic signed [23:0] grad_y;
	logic               end_of_element;
	logic               result_valid;
	logic [1:0]         row_basis;
	logic [1:0]         col_basis;
	logic signed [31:0] stiffness_value;
	logic signed [31:0] mass_value;
	logic signed [31:0] perp_even_value;
	logic signed [31:0] perp_odd_value;
	logic               last_entry;

	logic signed [23:0] weight_mem[NP];
	logic signed [23:0] det_mem[NP];
	logic signed [23:0] value_mem[NB*NP];
	logic signed [23:0] gradx_mem[NB*NP];
	logic signed [23:0] grady_mem[NB*NP];

	entry_t pending_entries[$];
	row_t   directed_rows[$];
	int     failures;
	int     cycles;
	int     burst_left;

	quad_element_matrix_assembly dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point_index(point_index),
		.basis_index(basis_index),
		.quad_weight(quad_weight),
		.jacobian_det(jacobian_det),
		.basis_value(basis_value),
		.grad_x(grad_x),
		.grad_y(grad_y),
		.end_of_element(end_of_element),
		.result_valid(result_valid),
		.row_basis(row_basis),
		.col_basis(col_basis),
		.stiffness_value(stiffness_value),
		.mass_value(mass_value),
		.perp_even_value(perp_even_value),
		.perp_odd_value(perp_odd_value),
		.last_entry(last_entry)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] round_q12(input logic signed [127:0] x);
		logic signed [127:0] r;
		r = (x + (128'sd1 <<< 59)) >>> 60;
		if (r > 128'sd2147483647)
			return 32'sh7FFFFFFF;
		if (r < -128'sd2147483648)
			return 32'sh80000000;
		return r[31:0];
	endfunction

	task automatic predict_element(input chk_t chk);
		logic signed [127:0] s, vi, st, ms, pe, po;
		logic signed [127:0] dabs, gxi, gyi, gxj, gyj, vj;
		int ei, ej;
		entry_t e;
		for (int i = 0; i < NB; i++) begin
			for (int j = 0; j < NB; j++) begin
				st = 0;
				ms = 0;
				pe = 0;
				po = 0;
				for (int k = 0; k < NP; k++) begin
					ei = i * NP + k;
					ej = j * NP + k;
					dabs = det_mem[k];
					if (dabs < 0)
						dabs = -dabs;
					s = weight_mem[k];
					s = s * dabs;
					vi = value_mem[ei];
					vj = value_mem[ej];
					gxi = gradx_mem[ei];
					gyi = grady_mem[ei];
					gxj = gradx_mem[ej];
					gyj = grady_mem[ej];
					st = st + s * (gxi * gxj + gyi * gyj);
					ms = ms + s * (vi * vj);
					pe = pe + s * (vi * gyj);
					po = po + s * (vi * gxj);
				end
				e.i = 2'(i);
				e.j = 2'(j);
				e.last = (i == NB - 1) && (j == NB - 1);
				case (chk)
					CHK_ZERO: begin
						e.stiff = 0;
						e.mass = 0;
						e.peven = 0;
						e.podd = 0;
					end
					CHK_SAT: begin
						e.stiff = 32'sh80000000;
						e.mass = 32'sh7FFFFFFF;
						e.peven = 32'sh80000000;
						e.podd = 32'sh7FFFFFFF;
					end
					default: begin
						e.stiff = round_q12(-st);
						e.mass = round_q12(ms);
						e.peven = round_q12(-pe);
						e.podd = round_q12(po);
					end
				endcase
				pending_entries.push_back(e);
			end
		end
	endtask

	task automatic send_row(input row_t r);
		int eidx;
		start <= 1'b1;
		point_index <= r.pt;
		basis_index <= r.bs;
		quad_weight <= r.w;
		jacobian_det <= r.d;
		basis_value <= r.v;
		grad_x <= r.gx;
		grad_y <= r.gy;
		end_of_element <= r.eoe;
		do
			@(posedge clk);
		while (busy);
		eidx = r.bs * NP + r.pt;
		weight_mem[r.pt] = r.w;
		det_mem[r.pt] = r.d;
		value_mem[eidx] = r.v;
		gradx_mem[eidx] = r.gx;
		grady_mem[eidx] = r.gy;
		if (r.eoe)
			predict_element(r.chk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	function automatic logic signed [23:0] rand_q4(input bit wild);
		case ($urandom_range(0, wild ? 4 : 2))
			0: return 24'($urandom_range(0, 2097152) - 1048576);
			1: return 24'($urandom_range(0, 1048576));
			2: return 24'($urandom_range(0, 65536) - 32768);
			3: return 24'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0: return 24'sh7FFFFF;
					1: return 24'sh800000;
					2: return 24'sh000000;
					default: return 24'shFFFFFF;
				endcase
			end
		endcase
	endfunction

	function automatic row_t make_row(input int pt, input int bs, input bit wild);
		row_t r;
		r.pt = 2'(pt);
		r.bs = 2'(bs);
		r.w = rand_q4(wild);
		r.d = rand_q4(wild);
		r.v = rand_q4(wild);
		r.gx = rand_q4(wild);
		r.gy = rand_q4(wild);
		r.eoe = 1'b0;
		r.chk = CHK_PREDICT;
		return r;
	endfunction

	function automatic row_t fixed_row(input int pt, input int bs,
			input logic signed [23:0] w, input logic signed [23:0] d,
			input logic signed [23:0] v, input logic signed [23:0] gx,
			input logic signed [23:0] gy, input logic eoe, input chk_t chk);
		row_t r;
		r.pt = 2'(pt);
		r.bs = 2'(bs);
		r.w = w;
		r.d = d;
		r.v = v;
		r.gx = gx;
		r.gy = gy;
		r.eoe = eoe;
		r.chk = chk;
		return r;
	endfunction

	always @(posedge clk) begin
		entry_t e;
		if (arst_n && result_valid) begin
			if (pending_entries.size() == 0) begin
				$error("unexpected result transaction at row %0d col %0d",
					row_basis, col_basis);
				failures++;
			end else begin
				e = pending_entries.pop_front();
				if (row_basis !== e.i) begin
					$error("row_basis: expected %0d, got %0d", e.i, row_basis);
					failures++;
				end
				if (col_basis !== e.j) begin
					$error("col_basis: expected %0d, got %0d", e.j, col_basis);
					failures++;
				end
				if (stiffness_value !== e.stiff) begin
					$error("stiffness_value: expected %0d, got %0d", e.stiff,
						stiffness_value);
					failures++;
				end
				if (mass_value !== e.mass) begin
					$error("mass_value: expected %0d, got %0d", e.mass, mass_value);
					failures++;
				end
				if (perp_even_value !== e.peven) begin
					$error("perp_even_value: expected %0d, got %0d", e.peven,
						perp_even_value);
					failures++;
				end
				if (perp_odd_value !== e.podd) begin
					$error("perp_odd_value: expected %0d, got %0d", e.podd,
						perp_odd_value);
					failures++;
				end
				if (last_entry !== e.last) begin
					$error("last_entry: expected %0d, got %0d", e.last, last_entry);
					failures++;
				end
			end
		end
	end

	initial begin
		int sent;
		int n_rows;
		int order[NB*NP];
		int tmp;
		int pick;
		row_t r;

		failures = 0;
		cycles = 0;
		burst_left = 1;
		arst_n = 1'b0;
		start = 1'b0;
		point_index = '0;
		basis_index = '0;
		quad_weight = '0;
		jacobian_det = '0;
		basis_value = '0;
		grad_x = '0;
		grad_y = '0;
		end_of_element = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full element at the positive extremes with the most negative determinant.
		for (int bs = 0; bs < NB; bs++)
			for (int pt = 0; pt < NP; pt++)
				directed_rows.push_back(fixed_row(pt, bs, 24'sh7FFFFF, 24'sh800000,
					24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
					(bs == NB - 1) && (pt == NP - 1), CHK_SAT));
		// Zero weights on every point cancel all sums.
		for (int pt = 0; pt < NP; pt++)
			directed_rows.push_back(fixed_row(pt, pt, 24'sh000000, 24'sh800000,
				24'sh800000, 24'sh800000, 24'sh7FFFFF, pt == NP - 1, CHK_ZERO));
		// Negative extremes and repeated point rows, where the last weight written wins.
		directed_rows.push_back(fixed_row(0, 1, 24'sh800000, 24'sh800000,
			24'sh800000, 24'sh800000, 24'sh800000, 1'b0, CHK_PREDICT));
		directed_rows.push_back(fixed_row(0, 2, 24'sh100000, 24'shF00000,
			24'sh080000, 24'shFFFFFF, 24'sh000001, 1'b1, CHK_PREDICT));
		directed_rows.push_back(fixed_row(3, 3, 24'sh000001, 24'shFFFFFF,
			24'sh7FFFFF, 24'sh800000, 24'sh000000, 1'b1, CHK_PREDICT));
		foreach (directed_rows[n])
			send_row(directed_rows[n]);

		start <= 1'b0;
		wait (pending_entries.size() == 0);
		@(posedge clk);

		sent = 0;
		while (sent < N_RANDOM) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				foreach (order[n])
					order[n] = n;
				for (int n = NB * NP - 1; n > 0; n--) begin
					tmp = $urandom_range(0, n);
					{order[n], order[tmp]} = {order[tmp], order[n]};
				end
				n_rows = NB * NP;
			end else begin
				foreach (order[n])
					order[n] = $urandom_range(0, NB * NP - 1);
				n_rows = $urandom_range(1, 5);
			end
			for (int n = 0; n < n_rows; n++) begin
				r = make_row(order[n] % NP, order[n] / NP, pick >= 5);
				r.eoe = (n == n_rows - 1) ? (pick != 9 || $urandom_range(0, 1)) :
					($urandom_range(0, 40) == 0);
				send_row(r);
				sent++;
			end
		end

		start <= 1'b0;
		wait (pending_entries.size() == 0);
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
